FILE: rtl/rar_pkg.sv
// Shared types for the rational add-and-reduce block.
package rar_pkg;

    // Classification the front end attaches to each queued item
    typedef struct packed {
        logic num_neg;   // cross-multiplied sum is negative
        logic num_zero;  // cross-multiplied sum is zero
        logic den_zero;  // product denominator is zero
    } rar_class_t;

endpackage

FILE: rtl/rar_front.sv
// Front end: multiplies out the two fractions, forms the sum and classifies it.
module rar_front #(
    parameter int VALUE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [VALUE_BITS-1:0] s_num_a,
    input  logic        [VALUE_BITS-2:0] s_den_a,
    input  logic signed [VALUE_BITS-1:0] s_num_b,
    input  logic        [VALUE_BITS-2:0] s_den_b,
    output logic                        push_valid,
    input  logic                        push_ready,
    output rar_pkg::rar_class_t         push_class,
    output logic [2*VALUE_BITS-2:0]     push_num_mag,
    output logic [2*VALUE_BITS-3:0]     push_den_mag
);

    localparam int PW = 2 * VALUE_BITS;

    logic                 st_valid_reg, st_valid_next;
    logic signed [PW-1:0] prod_a_reg, prod_a_next;
    logic signed [PW-1:0] prod_b_reg, prod_b_next;
    logic [PW-3:0]        prod_d_reg, prod_d_next;
    logic signed [PW-1:0] sum;
    logic [PW-1:0]        sum_abs;

    assign s_ready = !st_valid_reg || push_ready;

    always_comb begin
        prod_a_next   = prod_a_reg;
        prod_b_next   = prod_b_reg;
        prod_d_next   = prod_d_reg;
        st_valid_next = st_valid_reg;
        if (s_ready) begin
            st_valid_next = s_valid;
        end
        if (s_valid && s_ready) begin
            prod_a_next = s_num_a * $signed({1'b0, s_den_b});
            prod_b_next = s_num_b * $signed({1'b0, s_den_a});
            prod_d_next = s_den_a * s_den_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        prod_d_reg <= prod_d_next;
    end

    // Sum cannot overflow: both products are below 2^(PW-2) in magnitude
    assign sum     = prod_a_reg + prod_b_reg;
    assign sum_abs = sum[PW-1] ? PW'(-sum) : PW'(sum);

    assign push_valid          = st_valid_reg;
    assign push_num_mag        = sum_abs[PW-2:0];
    assign push_den_mag        = prod_d_reg;
    assign push_class.num_neg  = sum[PW-1];
    assign push_class.num_zero = (sum == '0);
    assign push_class.den_zero = (prod_d_reg == '0);

endmodule

FILE: rtl/rar_queue.sv
// Small FIFO that decouples the front end from the reduction engine.
module rar_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/rar_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rar_divider #(
    parameter int W = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/rar_back.sv
// Reduction engine: truncating Euclid and the two final divisions on one divider.
module rar_back #(
    parameter int VALUE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  rar_pkg::rar_class_t           q_class,
    input  logic [2*VALUE_BITS-2:0]       q_num_mag,
    input  logic [2*VALUE_BITS-3:0]       q_den_mag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [2*VALUE_BITS-1:0] m_sum_num,
    output logic signed [2*VALUE_BITS-2:0] m_sum_den
);

    localparam int W  = 2 * VALUE_BITS - 1;
    localparam int DW = 2 * VALUE_BITS - 2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_STEP = 6'b000010,
        ST_REM  = 6'b000100,
        ST_QNUM = 6'b001000,
        ST_QDEN = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [W-1:0]         num_mag_reg, num_mag_next;
    logic [DW-1:0]        den_mag_reg, den_mag_next;
    logic [W-1:0]         x_reg, x_next;
    logic [W-1:0]         y_reg, y_next;
    logic                 parity_reg, parity_next;
    logic                 num_neg_reg, num_neg_next;
    logic                 gneg_reg, gneg_next;
    logic [W-1:0]         qn_reg, qn_next;
    logic [DW-1:0]        qd_reg, qd_next;
    logic                 m_valid_reg, m_valid_next;
    logic signed [W:0]    m_sum_num_reg, m_sum_num_next;
    logic signed [DW:0]   m_sum_den_reg, m_sum_den_next;

    logic                 div_start;
    logic [W-1:0]         div_dividend;
    logic [W-1:0]         div_divisor;
    logic                 div_done;
    logic [W-1:0]         div_quotient;
    logic [W-1:0]         div_remainder;

    rar_divider #(
        .W(W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign q_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        num_mag_next   = num_mag_reg;
        den_mag_next   = den_mag_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        parity_next    = parity_reg;
        num_neg_next   = num_neg_reg;
        gneg_next      = gneg_reg;
        qn_next        = qn_reg;
        qd_next        = qd_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_sum_num_next = m_sum_num_reg;
        m_sum_den_next = m_sum_den_reg;
        div_start      = 1'b0;
        div_dividend   = x_reg;
        div_divisor    = y_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    num_mag_next = q_num_mag;
                    den_mag_next = q_den_mag;
                    x_next       = q_num_mag;
                    y_next       = W'(q_den_mag);
                    parity_next  = 1'b0;
                    num_neg_next = q_class.num_neg;
                    if (q_class.num_zero || q_class.den_zero) begin
                        // Zero sum gives 0/1, zero denominator gives 1/0, both give 0/0
                        qn_next      = q_class.num_zero ? '0 : W'(1);
                        qd_next      = q_class.den_zero ? '0 : DW'(1);
                        gneg_next    = 1'b0;
                        num_neg_next = 1'b0;
                        state_next   = ST_EMIT;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (y_reg == '0) begin
                    // Divisor found; signed like the numerator after an even step count
                    gneg_next    = !parity_reg && num_neg_reg;
                    div_start    = 1'b1;
                    div_dividend = num_mag_reg;
                    div_divisor  = x_reg;
                    state_next   = ST_QNUM;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_REM;
                end
            end
            ST_REM: begin
                if (div_done) begin
                    x_next      = y_reg;
                    y_next      = div_remainder;
                    parity_next = !parity_reg;
                    state_next  = ST_STEP;
                end
            end
            ST_QNUM: begin
                if (div_done) begin
                    qn_next      = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = W'(den_mag_reg);
                    div_divisor  = x_reg;
                    state_next   = ST_QDEN;
                end
            end
            ST_QDEN: begin
                if (div_done) begin
                    qd_next    = div_quotient[DW-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_sum_num_next = (num_neg_reg ^ gneg_reg) ? -$signed({1'b0, qn_reg})
                                                              : $signed({1'b0, qn_reg});
                    m_sum_den_next = gneg_reg ? -$signed({1'b0, qd_reg})
                                              : $signed({1'b0, qd_reg});
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_mag_reg   <= num_mag_next;
        den_mag_reg   <= den_mag_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        parity_reg    <= parity_next;
        num_neg_reg   <= num_neg_next;
        gneg_reg      <= gneg_next;
        qn_reg        <= qn_next;
        qd_reg        <= qd_next;
        m_sum_num_reg <= m_sum_num_next;
        m_sum_den_reg <= m_sum_den_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_sum_num = m_sum_num_reg;
    assign m_sum_den = m_sum_den_reg;

endmodule

FILE: rtl/rational_add_reduce.sv
// Top level of the rational add-and-reduce block: front end, queue, reduction engine.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | s_valid / s_ready  | s_num_a, s_den_a, s_num_b, s_den_b
//  result   | m_valid / m_ready  | m_sum_num, m_sum_den
//
// An item uses one divider run per Euclid remainder step and one for each of the
// two final divisions, between a load state and an emit state, with W = 2*VALUE_BITS-1:
// the shared divider is W bits wide and produces one quotient bit per cycle.
// Zero sums and zero denominators skip the divider and go straight from load to emit.
// Reset (aresetn, synchronous, active low) empties the front stage, the queue,
// the engine and the result register; nothing needs a clearing pass.
// The front end keeps accepting items into the queue while the engine works
// or while a result waits on m_ready; it stalls only when the queue is full.
module rational_add_reduce #(
    parameter int VALUE_BITS  = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_num_a,
    input  logic        [VALUE_BITS-2:0]  s_den_a,
    input  logic signed [VALUE_BITS-1:0]  s_num_b,
    input  logic        [VALUE_BITS-2:0]  s_den_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [2*VALUE_BITS-1:0] m_sum_num,
    output logic signed [2*VALUE_BITS-2:0] m_sum_den
);

    // Magnitude widths of the cross-multiplied sum and the product denominator
    localparam int NW = 2 * VALUE_BITS - 1;
    localparam int DW = 2 * VALUE_BITS - 2;
    localparam int CLW = $bits(rar_pkg::rar_class_t);
    localparam int QW = CLW + NW + DW;

    logic                push_valid;
    logic                push_ready;
    rar_pkg::rar_class_t push_class;
    logic [NW-1:0]       push_num_mag;
    logic [DW-1:0]       push_den_mag;
    logic [QW-1:0]       push_data;

    logic                pop_valid;
    logic                pop_ready;
    logic [QW-1:0]       pop_data;
    rar_pkg::rar_class_t pop_class;
    logic [NW-1:0]       pop_num_mag;
    logic [DW-1:0]       pop_den_mag;

    // Multiply out and classify
    rar_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_num_a      (s_num_a),
        .s_den_a      (s_den_a),
        .s_num_b      (s_num_b),
        .s_den_b      (s_den_b),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_class   (push_class),
        .push_num_mag (push_num_mag),
        .push_den_mag (push_den_mag)
    );

    assign push_data = {push_class, push_num_mag, push_den_mag};

    // Buffer classified items so the front end runs ahead of the engine
    rar_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    assign {pop_class, pop_num_mag, pop_den_mag} = pop_data;

    // Reduce one item at a time and hold the result until taken
    rar_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_class   (pop_class),
        .q_num_mag (pop_num_mag),
        .q_den_mag (pop_den_mag),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sum_num (m_sum_num),
        .m_sum_den (m_sum_den)
    );

endmodule

FILE: rtl/rar_checker.sv
// Port-level checks for the rational add-and-reduce block, bound to the top level.
module rar_checker #(
    parameter int VALUE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [VALUE_BITS-1:0]  s_num_a,
    input logic        [VALUE_BITS-2:0]  s_den_a,
    input logic signed [VALUE_BITS-1:0]  s_num_b,
    input logic        [VALUE_BITS-2:0]  s_den_b,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [2*VALUE_BITS-1:0] m_sum_num,
    input logic signed [2*VALUE_BITS-2:0] m_sum_den
);

    logic [3:0] outstanding_reg, outstanding_next;
    logic       in_take, out_take;

    assign in_take  = s_valid && s_ready;
    assign out_take = m_valid && m_ready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (in_take && !out_take) begin
            outstanding_next = outstanding_reg + 1'b1;
        end else if (out_take && !in_take) begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // Input side holds a stalled item
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_num_a) && $stable(s_den_a)
                                && $stable(s_num_b) && $stable(s_den_b))
        else $error("input item changed while stalled");

    // Result side holds a stalled item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_num) && $stable(m_sum_den))
        else $error("result item changed while stalled");

    // No result without an accepted item behind it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != '0)
        else $error("result shown with no item outstanding");

    // A zero denominator only comes out as 1/0 or 0/0
    a_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sum_den == '0 |-> m_sum_num == '0 || m_sum_num == 1)
        else $error("zero denominator with unexpected numerator");

    // A zero numerator only comes out as 0/1 or 0/0
    a_zero_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sum_num == '0 |-> m_sum_den == '0 || m_sum_den == 1)
        else $error("zero numerator not reduced to 0/1");

endmodule

bind rational_add_reduce rar_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_rar_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_num_a   (s_num_a),
    .s_den_a   (s_den_a),
    .s_num_b   (s_num_b),
    .s_den_b   (s_den_b),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_sum_num (m_sum_num),
    .m_sum_den (m_sum_den)
);
